// ===== hw/rtl/fdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fdc_pkg: shared types and constants
// Event modes, command and special register codes, result codes, status
// values, and drive request, motor and timer command codes.
// ----------------------------------------------------------------------------
package fdc_pkg;

  typedef enum logic [3:0] {
    MODE_BUS_RD    = 4'd0,
    MODE_BUS_WR    = 4'd1,
    MODE_CALLBACK  = 4'd2,
    MODE_DATA_BYTE = 4'd3,
    MODE_FINISH_RD = 4'd4,
    MODE_NOT_FOUND = 4'd5,
    MODE_DATA_CRC  = 4'd6,
    MODE_HDR_CRC   = 4'd7,
    MODE_WR_PROT   = 4'd8,
    MODE_BYTE_WANT = 4'd9,
    MODE_SPINDOWN  = 4'd10
  } mode_t;

  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_READ      = 3'd1;
  localparam logic [2:0] OP_WRITE     = 3'd2;
  localparam logic [2:0] OP_READ_ID   = 3'd3;
  localparam logic [2:0] OP_FORMAT    = 3'd4;
  localparam logic [2:0] OP_SEEK_REL  = 3'd5;
  localparam logic [2:0] OP_SEEK_TRK0 = 3'd6;

  localparam logic [2:0] MOT_NONE  = 3'd0;
  localparam logic [2:0] MOT_UP    = 3'd1;
  localparam logic [2:0] MOT_SHORT = 3'd2;
  localparam logic [2:0] MOT_TIMED = 3'd3;
  localparam logic [2:0] MOT_OFF   = 3'd4;

  localparam logic [1:0] TMR_NONE   = 2'd0;
  localparam logic [1:0] TMR_CANCEL = 2'd1;
  localparam logic [1:0] TMR_SCHED  = 2'd2;

  localparam logic [2:0] ADDR_STATUS = 3'd0;
  localparam logic [2:0] ADDR_RESULT = 3'd1;
  localparam logic [2:0] ADDR_RESET  = 3'd2;
  localparam logic [2:0] ADDR_DATA   = 3'd4;

  localparam logic [7:0] CMD_SCAN_A    = 8'h00;
  localparam logic [7:0] CMD_SCAN_B    = 8'h04;
  localparam logic [7:0] CMD_WR_ONE    = 8'h0A;
  localparam logic [7:0] CMD_WR_MULTI  = 8'h0B;
  localparam logic [7:0] CMD_WRD_ONE   = 8'h0E;
  localparam logic [7:0] CMD_WRD_MULTI = 8'h0F;
  localparam logic [7:0] CMD_RD_ONE    = 8'h12;
  localparam logic [7:0] CMD_RD_MULTI  = 8'h13;
  localparam logic [7:0] CMD_RDD_ONE   = 8'h16;
  localparam logic [7:0] CMD_RDD_MULTI = 8'h17;
  localparam logic [7:0] CMD_RD_ID     = 8'h1B;
  localparam logic [7:0] CMD_VFY_ONE   = 8'h1E;
  localparam logic [7:0] CMD_VFY_MULTI = 8'h1F;
  localparam logic [7:0] CMD_FORMAT    = 8'h23;
  localparam logic [7:0] CMD_SEEK      = 8'h29;
  localparam logic [7:0] CMD_STATUS    = 8'h2C;
  localparam logic [7:0] CMD_SPECIFY   = 8'h35;
  localparam logic [7:0] CMD_WR_SPEC   = 8'h3A;
  localparam logic [7:0] CMD_RD_SPEC   = 8'h3D;
  localparam logic [7:0] CMD_NONE      = 8'hFF;

  localparam logic [7:0] SR_SCAN   = 8'h06;
  localparam logic [7:0] SR_TRK0   = 8'h12;
  localparam logic [7:0] SR_MODE   = 8'h17;
  localparam logic [7:0] SR_TRK1   = 8'h1A;
  localparam logic [7:0] SR_DRVOUT = 8'h23;
  localparam logic [7:0] SPEC_INIT = 8'h0D;

  localparam logic [7:0] RES_FAIL     = 8'h18;
  localparam logic [7:0] RES_DATA_CRC = 8'h0E;
  localparam logic [7:0] RES_HDR_CRC  = 8'h0C;
  localparam logic [7:0] RES_WR_PROT  = 8'h12;
  localparam logic [7:0] RES_DELETED  = 8'h20;

  localparam logic [7:0] ST_BUSY   = 8'h80;
  localparam logic [7:0] ST_RESULT = 8'h10;
  localparam logic [7:0] ST_DONE   = 8'h18;
  localparam logic [7:0] ST_XFER   = 8'h8C;

endpackage : fdc_pkg
`default_nettype wire

// ===== hw/rtl/floppy_disk_controller_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// floppy_disk_controller_core: 8271-style floppy controller register model
// Decodes bus accesses and drive events, keeps the command state and
// issues seek, sector and motor requests, one result item per event item.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload (low bit first)
//  in      | in_tvalid / in_tready   | tuser: mode[3:0]; tlast: last_byte
//          |                         | tdata: reg_addr[2:0] write_value[10:3]
//          |                         |        disc_byte[18:11] deleted[19]
//  out     | out_tvalid / out_tready | tdata: read_value status disc_op drive
//          |                         |   side track operand include_deleted
//          |                         |   motor_cmd timer_cmd step settle
//
// One item per cycle while the output is not stalled; the result item appears in the cycle after acceptance.
// The controller state is updated in the accept cycle from a single pass of
// decode logic. The output register holds its item while out_tready is low;
// in_tready is high whenever that register is empty or being drained.
// rst_n is synchronous and active low.
// ----------------------------------------------------------------------------
module floppy_disk_controller_core #(
  parameter int PARAM_SLOTS = 5
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode
  input  wire logic [3:0]   in_tuser,
  input  wire logic         in_tlast,
  // reg_addr, write_value, disc_byte, deleted
  input  wire logic [23:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // read_value, status, disc_op, drive, side, track, operand, include_deleted,
  // motor_cmd, timer_cmd, step_cycles, settle_cycles
  output logic [95:0]       out_tdata
);
  import fdc_pkg::*;

  localparam int PW = $clog2(PARAM_SLOTS + 1);

  logic [3:0] mode;
  logic [2:0] addr;
  logic [7:0] wv, db;
  logic       del, last;
  assign mode = in_tuser;
  assign addr = in_tdata[2:0];
  assign wv   = in_tdata[10:3];
  assign db   = in_tdata[18:11];
  assign del  = in_tdata[19];
  assign last = in_tlast;

  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  par_r [PARAM_SLOTS];
  logic [7:0]  par_nxt [PARAM_SLOTS];
  logic [PW-1:0] pcnt_r, pcnt_nxt, pneed_r, pneed_nxt;
  logic [7:0]  st_r, st_nxt, res_r, res_nxt;
  logic [7:0]  trk_r [2];
  logic [7:0]  trk_nxt [2];
  logic [7:0]  sec_r, sec_nxt;
  logic [4:0]  srem_r, srem_nxt;
  logic [14:0] bps_r, bps_nxt, brem_r, brem_nxt;
  logic        dela_r, dela_nxt, phase_r, phase_nxt, dw_r, dw_nxt;
  logic [7:0]  dreg_r, dreg_nxt, dout_r, dout_nxt;
  logic [3:0]  unl_r, unl_nxt;
  logic [18:0] step_r, step_nxt, settle_r, settle_nxt;
  logic        cdrv_r, cdrv_nxt, mot_r, mot_nxt;

  logic [8:0]  o_read;
  logic [2:0]  o_op, o_motor;
  logic [7:0]  o_track;
  logic [16:0] o_operand;
  logic        o_incl;
  logic [1:0]  o_timer;
  logic [18:0] o_step, o_settle;

  logic        ovalid_r;
  logic [95:0] odata_r;
  logic        acc;

  assign in_tready  = !ovalid_r || out_tready;
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  always_comb begin
    logic [7:0]  c, p2;
    logic [PW-1:0] pc;
    logic        d, doprep, cd_done;
    logic [7:0]  pn;
    logic [4:0]  pcount;
    logic [14:0] psize;
    logic        pdel;
    // commit registers
    cmd_nxt = cmd_r; pcnt_nxt = pcnt_r; pneed_nxt = pneed_r;
    st_nxt = st_r; res_nxt = res_r; trk_nxt = trk_r; sec_nxt = sec_r;
    srem_nxt = srem_r; bps_nxt = bps_r; brem_nxt = brem_r; dela_nxt = dela_r;
    phase_nxt = phase_r; dw_nxt = dw_r; dreg_nxt = dreg_r; dout_nxt = dout_r;
    unl_nxt = unl_r; step_nxt = step_r; settle_nxt = settle_r;
    cdrv_nxt = cdrv_r; mot_nxt = mot_r; par_nxt = par_r;
    o_read = 9'h1FF; o_op = OP_NONE; o_track = '0; o_operand = '0; o_incl = 1'b0;
    o_motor = MOT_NONE; o_timer = TMR_NONE; o_step = '0; o_settle = '0;
    c = '0; p2 = par_r[2]; pc = pcnt_r; d = cdrv_r; doprep = 1'b0;
    cd_done = 1'b0; pn = '0; pcount = '0; psize = '0; pdel = 1'b0;
    case (mode)
      MODE_BUS_RD: begin
        if (addr == ADDR_STATUS) o_read = {1'b0, st_r};
        else if (addr == ADDR_RESULT) begin
          st_nxt = st_r & ~8'h18; o_read = {1'b0, res_r};
        end else if (addr == ADDR_DATA) begin
          st_nxt = st_r & ~8'h0C; o_read = {1'b0, dreg_r};
        end else o_read = '0;
      end
      MODE_BUS_WR: begin
        if (addr == ADDR_STATUS) begin
          if (!st_r[7]) begin
            c = {2'b00, wv[5:0]};
            if (c == CMD_RDD_MULTI) c = CMD_RD_MULTI;
            cmd_nxt = c;
            if (c < CMD_STATUS) dout_nxt = {wv[7:6], dout_r[5:0]};
            cdrv_nxt = wv[7];
            pcnt_nxt = '0;
            st_nxt = ST_BUSY;
            case (c)
              CMD_STATUS: begin
                pneed_nxt = '0; st_nxt = ST_RESULT;
                res_nxt = 8'h88 | ((trk_r[wv[7]] != 0) ? 8'h00 : 8'h02);
                if (dout_nxt[6]) res_nxt = res_nxt | 8'h04;
                if (dout_nxt[7]) res_nxt = res_nxt | 8'h40;
              end
              CMD_SEEK, CMD_RD_SPEC: pneed_nxt = PW'(1);
              CMD_WR_ONE, CMD_WRD_ONE, CMD_RD_ONE, CMD_RDD_ONE, CMD_VFY_ONE,
              CMD_WR_SPEC: pneed_nxt = PW'(2);
              CMD_WR_MULTI, CMD_WRD_MULTI, CMD_RD_MULTI, CMD_VFY_MULTI,
              CMD_RD_ID: pneed_nxt = PW'(3);
              CMD_SPECIFY: pneed_nxt = PW'(4);
              CMD_SCAN_A, CMD_SCAN_B, CMD_FORMAT: pneed_nxt = PW'(5);
              default: begin
                pneed_nxt = '0; res_nxt = RES_FAIL; st_nxt = ST_DONE;
                o_timer = TMR_CANCEL;
              end
            endcase
          end
        end else if (addr == ADDR_RESULT) begin
          if (pcnt_r < PW'(PARAM_SLOTS)) begin
            for (int i = 0; i < PARAM_SLOTS; i++)
              if (pcnt_r == PW'(i)) par_nxt[i] = wv;
            pc = pcnt_r + PW'(1);
            pcnt_nxt = pc;
          end
          if (pc == pneed_r) begin
            p2 = par_nxt[2];
            case (cmd_r)
              CMD_WR_ONE, CMD_RD_ONE: begin
                doprep = 1'b1; pn = 8'd1; psize = 15'd128;
              end
              CMD_WRD_ONE, CMD_RDD_ONE: begin
                doprep = 1'b1; pn = 8'd1; psize = 15'd128; pdel = 1'b1;
              end
              CMD_WR_MULTI, CMD_RD_MULTI: begin
                doprep = 1'b1; pn = p2; psize = 15'd128 << p2[7:5];
              end
              CMD_WRD_MULTI: begin
                doprep = 1'b1; pn = p2; psize = 15'd128 << p2[7:5]; pdel = 1'b1;
              end
              CMD_VFY_ONE: begin doprep = 1'b1; pn = 8'd1; pdel = 1'b1; end
              CMD_VFY_MULTI: begin doprep = 1'b1; pn = p2; pdel = 1'b1; end
              CMD_RD_ID: begin doprep = 1'b1; pn = p2; psize = 15'd4; end
              CMD_FORMAT: begin
                mot_nxt = 1'b1; o_motor = MOT_UP; phase_nxt = 1'b0;
              end
              CMD_SEEK: begin mot_nxt = 1'b1; o_motor = MOT_UP; end
              CMD_SPECIFY: begin
                // The head load time has no effect on any result, so it is
                // not stored.
                if (par_nxt[0] == SPEC_INIT) begin
                  step_nxt   = 19'(par_nxt[1] * 11'd2000);
                  settle_nxt = 19'(par_nxt[2] * 11'd2000);
                  unl_nxt    = par_nxt[3][7:4];
                end
                st_nxt = '0;
              end
              CMD_WR_SPEC: begin
                st_nxt = '0;
                case (par_nxt[0])
                  SR_TRK0: trk_nxt[0] = wv;
                  SR_MODE: ;
                  SR_TRK1: trk_nxt[1] = wv;
                  SR_DRVOUT: dout_nxt = par_nxt[1];
                  default: begin
                    res_nxt = RES_FAIL; st_nxt = ST_DONE; o_timer = TMR_CANCEL;
                  end
                endcase
              end
              CMD_RD_SPEC: begin
                st_nxt = ST_RESULT;
                case (par_nxt[0])
                  SR_SCAN: res_nxt = '0;
                  SR_TRK0: res_nxt = trk_r[0];
                  SR_TRK1: res_nxt = trk_r[1];
                  SR_DRVOUT: res_nxt = dout_r;
                  default: begin
                    res_nxt = RES_FAIL; st_nxt = ST_DONE; o_timer = TMR_CANCEL;
                  end
                endcase
              end
              default: begin
                res_nxt = RES_FAIL; st_nxt = ST_DONE; o_timer = TMR_CANCEL;
              end
            endcase
            if (doprep) begin
              sec_nxt = par_nxt[1]; srem_nxt = pn[4:0]; bps_nxt = psize;
              dela_nxt = pdel; mot_nxt = 1'b1; o_motor = MOT_UP; phase_nxt = 1'b0;
            end
            if (doprep || cmd_r == CMD_FORMAT || cmd_r == CMD_SEEK) begin
              o_track = par_nxt[0]; o_step = step_r; o_settle = settle_r;
              if (par_nxt[0] != 0) begin
                o_op = OP_SEEK_REL;
                o_operand = {9'd0, par_nxt[0]} - {9'd0, trk_r[cdrv_r]};
              end else o_op = OP_SEEK_TRK0;
            end
          end
        end else if (addr == ADDR_RESET) begin
          if (wv[0]) begin
            o_motor = MOT_TIMED; o_operand = 17'd45000; o_timer = TMR_CANCEL;
            pcnt_nxt = '0; pneed_nxt = '0; st_nxt = '0;
            trk_nxt[0] = '0; trk_nxt[1] = '0; cmd_nxt = CMD_NONE;
          end
        end else if (addr == ADDR_DATA) begin
          dreg_nxt = wv; dw_nxt = 1'b1; st_nxt = st_r & ~8'h0C;
        end
      end
      MODE_CALLBACK: begin
        o_timer = TMR_CANCEL;
        pcount = srem_r - 5'd1;
        case (cmd_r)
          CMD_WR_ONE, CMD_WR_MULTI, CMD_WRD_ONE, CMD_WRD_MULTI, CMD_RD_ONE,
          CMD_RD_MULTI, CMD_RDD_ONE, CMD_VFY_ONE, CMD_VFY_MULTI,
          CMD_RD_ID: begin
            if (!phase_r) begin
              trk_nxt[d] = par_r[0]; phase_nxt = 1'b1;
            end else begin
              srem_nxt = pcount;
              if (pcount == 0) begin
                cd_done = 1'b1; st_nxt = ST_DONE; res_nxt = '0;
                o_motor = MOT_TIMED; o_operand = 17'(unl_r * 12'd3125);
              end else sec_nxt = sec_r + 8'd1;
            end
            if (!cd_done) begin
              o_track = par_r[0];
              if (cmd_r == CMD_RD_ID) begin
                o_op = OP_READ_ID;
                if (phase_r) brem_nxt = 15'd4;
              end else begin
                o_operand = {9'd0, sec_nxt}; o_incl = dela_r;
                if (cmd_r inside {CMD_WR_ONE, CMD_WR_MULTI, CMD_WRD_ONE,
                                  CMD_WRD_MULTI}) begin
                  o_op = OP_WRITE; st_nxt = ST_XFER; res_nxt = '0;
                  if (phase_r) brem_nxt = bps_r;
                end else begin
                  o_op = OP_READ; brem_nxt = bps_r;
                end
              end
            end
          end
          CMD_FORMAT: begin
            if (!phase_r) begin
              trk_nxt[d] = par_r[0]; o_op = OP_FORMAT; o_track = par_r[0];
              o_operand = {9'd0, par_r[2]}; st_nxt = ST_XFER; phase_nxt = 1'b1;
            end else begin
              st_nxt = ST_DONE; res_nxt = '0;
            end
          end
          CMD_SEEK: begin
            trk_nxt[d] = par_r[0]; st_nxt = ST_DONE; res_nxt = '0;
            o_motor = MOT_TIMED; o_operand = 17'(unl_r * 12'd3125);
          end
          default: ;
        endcase
      end
      MODE_DATA_BYTE: begin
        if (brem_r != 0) begin
          brem_nxt = brem_r - 15'd1; dreg_nxt = db; st_nxt = ST_XFER; res_nxt = '0;
        end
      end
      MODE_FINISH_RD: begin
        o_timer = TMR_SCHED;
        if (del) res_nxt = res_r | RES_DELETED;
      end
      MODE_NOT_FOUND: begin
        res_nxt = RES_FAIL; st_nxt = ST_DONE; o_motor = MOT_SHORT; o_timer = TMR_CANCEL;
      end
      MODE_DATA_CRC: begin
        res_nxt = RES_DATA_CRC | (del ? RES_DELETED : 8'h00); st_nxt = ST_DONE;
        o_motor = MOT_SHORT; o_timer = TMR_CANCEL;
      end
      MODE_HDR_CRC: begin
        res_nxt = RES_HDR_CRC; st_nxt = ST_DONE; o_motor = MOT_SHORT;
        o_timer = TMR_CANCEL;
      end
      MODE_WR_PROT: begin
        res_nxt = RES_WR_PROT; st_nxt = ST_DONE; o_motor = MOT_SHORT;
        o_timer = TMR_CANCEL;
      end
      MODE_BYTE_WANT: begin
        if (dw_r) begin
          if (!last) begin st_nxt = ST_XFER; res_nxt = '0; end
          dw_nxt = 1'b0; o_read = {1'b0, dreg_r};
        end
      end
      MODE_SPINDOWN: begin
        if (mot_r) begin mot_nxt = 1'b0; o_motor = MOT_OFF; end
        dout_nxt = {2'b00, dout_r[5:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= CMD_NONE; pcnt_r <= '0; pneed_r <= '0; st_r <= '0; res_r <= '0;
      trk_r[0] <= '0; trk_r[1] <= '0; sec_r <= '0; srem_r <= '0; bps_r <= '0;
      brem_r <= '0; dela_r <= 1'b0; phase_r <= 1'b0; dw_r <= 1'b0; dreg_r <= '0;
      dout_r <= '0; unl_r <= '0; step_r <= '0; settle_r <= '0;
      cdrv_r <= 1'b0; mot_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      if (acc) begin
        cmd_r <= cmd_nxt; pcnt_r <= pcnt_nxt; pneed_r <= pneed_nxt;
        st_r <= st_nxt; res_r <= res_nxt; trk_r <= trk_nxt; sec_r <= sec_nxt;
        srem_r <= srem_nxt; bps_r <= bps_nxt; brem_r <= brem_nxt;
        dela_r <= dela_nxt; phase_r <= phase_nxt; dw_r <= dw_nxt;
        dreg_r <= dreg_nxt; dout_r <= dout_nxt; unl_r <= unl_nxt;
        step_r <= step_nxt; settle_r <= settle_nxt;
        cdrv_r <= cdrv_nxt; mot_r <= mot_nxt;
      end
      if (acc) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  // Parameter bytes and the result payload need no reset.
  always_ff @(posedge clk) begin
    if (acc) begin
      par_r <= par_nxt;
      odata_r <= {5'd0, o_settle, o_step, o_timer, o_motor, o_incl, o_operand,
                  o_track, dout_nxt[5], cdrv_nxt, o_op, st_nxt, o_read};
    end
  end

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");
  a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item produced no result");
  a_pcnt: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PW'(PARAM_SLOTS))
    else $error("parameter count overflow");

endmodule : floppy_disk_controller_core
`default_nettype wire

// ===== dv/tb_floppy_disk_controller_core.sv =====
// ----------------------------------------------------------------------------
// tb_floppy_disk_controller_core: self-checking bench for the floppy core
// Drives bus accesses and drive events into the core, predicts each result
// item from a behavioral copy of the controller state and compares every
// field. Directed checks are followed by random command sequences.
// ----------------------------------------------------------------------------
module tb_floppy_disk_controller_core;
  import fdc_pkg::*;

  localparam logic [7:0] CMD_BAD = 8'h01;

  typedef struct packed {
    logic [8:0]  rd;
    logic [7:0]  status;
    logic [2:0]  op;
    logic        drive;
    logic        side;
    logic [7:0]  track;
    logic [16:0] operand;
    logic        incl;
    logic [2:0]  motor;
    logic [1:0]  timer;
    logic [18:0] step;
    logic [18:0] settle;
  } fdc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [3:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  floppy_disk_controller_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tlast(in_tlast), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Controller state as the bench believes it to be.
  logic [7:0]  cmd_code;
  logic [7:0]  pbytes [5];
  int          pcount, pneed;
  logic [7:0]  st_reg, res_reg, data_reg, drv_out, sec_now;
  logic [7:0]  trk [2];
  logic [4:0]  sec_left;
  logic [15:0] sec_bytes, bytes_left;
  logic        del_ok, phase, data_wr, cur_drv, motor_on;
  logic [3:0]  unload_cnt;
  logic [18:0] step_t, settle_t;
  fdc_result_t r;
  int          r_operand;

  fdc_result_t expected_items[$];
  int          n_errors = 0;
  bit          calm = 1'b0;

  function automatic void clear_state();
    cmd_code = CMD_NONE;
    foreach (pbytes[i]) pbytes[i] = '0;
    pcount = 0; pneed = 0;
    st_reg = '0; res_reg = '0; data_reg = '0; drv_out = '0; sec_now = '0;
    trk[0] = '0; trk[1] = '0; sec_left = '0; sec_bytes = '0; bytes_left = '0;
    del_ok = 0; phase = 0; data_wr = 0; cur_drv = 0; motor_on = 0;
    unload_cnt = '0; step_t = '0; settle_t = '0;
  endfunction

  function automatic void fail_code(logic [7:0] code);
    res_reg = code;
    st_reg = ST_DONE;
  endfunction

  function automatic void timed_down();
    r.motor = MOT_TIMED;
    r_operand = int'(unload_cnt) * 3125;
  endfunction

  function automatic void short_down();
    r.motor = MOT_SHORT;
    r.timer = TMR_CANCEL;
  endfunction

  function automatic void seek_req();
    r.track = pbytes[0];
    r.step = step_t;
    r.settle = settle_t;
    if (pbytes[0] != 0) begin
      r.op = OP_SEEK_REL;
      r_operand = int'(pbytes[0]) - int'(trk[cur_drv]);
    end else begin
      r.op = OP_SEEK_TRK0;
      r_operand = 0;
    end
  endfunction

  function automatic void start_xfer(logic [7:0] n, logic [15:0] size, logic del);
    sec_now = pbytes[1];
    sec_left = n[4:0];
    sec_bytes = size;
    del_ok = del;
    motor_on = 1; r.motor = MOT_UP;
    phase = 0;
    seek_req();
  endfunction

  function automatic void sector_req(logic [2:0] op);
    r.op = op;
    r.track = pbytes[0];
    r_operand = (op == OP_READ_ID) ? 0 : int'(sec_now);
    r.incl = (op == OP_READ_ID) ? 1'b0 : del_ok;
  endfunction

  // Returns 1 when the last sector of a transfer command is done.
  function automatic bit sector_done();
    sec_left = sec_left - 5'd1;
    if (sec_left == 0) begin
      st_reg = ST_DONE; res_reg = '0;
      timed_down();
      return 1'b1;
    end
    sec_now = sec_now + 8'd1;
    return 1'b0;
  endfunction

  function automatic void on_command(logic [7:0] v);
    logic [7:0] c;
    if (st_reg[7]) return;
    c = {2'b00, v[5:0]};
    if (c == CMD_RDD_MULTI) c = CMD_RD_MULTI;
    cmd_code = c;
    if (c < CMD_STATUS) drv_out = {v[7:6], drv_out[5:0]};
    cur_drv = v[7];
    pcount = 0;
    st_reg = ST_BUSY;
    case (c)
      CMD_STATUS: begin
        pneed = 0; st_reg = ST_RESULT;
        res_reg = 8'h88 | ((trk[cur_drv] != 0) ? 8'h00 : 8'h02);
        if (drv_out[6]) res_reg |= 8'h04;
        if (drv_out[7]) res_reg |= 8'h40;
      end
      CMD_SEEK, CMD_RD_SPEC: pneed = 1;
      CMD_WR_ONE, CMD_WRD_ONE, CMD_RD_ONE, CMD_RDD_ONE, CMD_VFY_ONE, CMD_WR_SPEC:
        pneed = 2;
      CMD_WR_MULTI, CMD_WRD_MULTI, CMD_RD_MULTI, CMD_VFY_MULTI, CMD_RD_ID: pneed = 3;
      CMD_SPECIFY: pneed = 4;
      CMD_SCAN_A, CMD_SCAN_B, CMD_FORMAT: pneed = 5;
      default: begin
        pneed = 0; fail_code(RES_FAIL); r.timer = TMR_CANCEL;
      end
    endcase
  endfunction

  function automatic void on_param(logic [7:0] v);
    logic [7:0] p2;
    logic [15:0] sz;
    if (pcount < 5) begin
      pbytes[pcount] = v;
      pcount++;
    end
    if (pcount != pneed) return;
    p2 = pbytes[2];
    sz = 16'd128 << p2[7:5];
    case (cmd_code)
      CMD_WR_ONE, CMD_RD_ONE: start_xfer(8'd1, 16'd128, 1'b0);
      CMD_WRD_ONE, CMD_RDD_ONE: start_xfer(8'd1, 16'd128, 1'b1);
      CMD_WR_MULTI, CMD_RD_MULTI: start_xfer(p2, sz, 1'b0);
      CMD_WRD_MULTI: start_xfer(p2, sz, 1'b1);
      CMD_VFY_ONE: start_xfer(8'd1, 16'd0, 1'b1);
      CMD_VFY_MULTI: start_xfer(p2, 16'd0, 1'b1);
      CMD_RD_ID: start_xfer(p2, 16'd4, 1'b0);
      CMD_FORMAT: begin
        motor_on = 1; r.motor = MOT_UP; phase = 0; seek_req();
      end
      CMD_SEEK: begin
        seek_req(); motor_on = 1; r.motor = MOT_UP;
      end
      CMD_SPECIFY: begin
        if (pbytes[0] == SPEC_INIT) begin
          step_t = pbytes[1] * 19'd2000;
          settle_t = pbytes[2] * 19'd2000;
          unload_cnt = pbytes[3][7:4];
        end
        st_reg = '0;
      end
      CMD_WR_SPEC: begin
        st_reg = '0;
        case (pbytes[0])
          SR_TRK0: trk[0] = v;
          SR_MODE: ;
          SR_TRK1: trk[1] = v;
          SR_DRVOUT: drv_out = pbytes[1];
          default: begin fail_code(RES_FAIL); r.timer = TMR_CANCEL; end
        endcase
      end
      CMD_RD_SPEC: begin
        st_reg = ST_RESULT; res_reg = '0;
        case (pbytes[0])
          SR_SCAN: res_reg = '0;
          SR_TRK0: res_reg = trk[0];
          SR_TRK1: res_reg = trk[1];
          SR_DRVOUT: res_reg = drv_out;
          default: begin fail_code(RES_FAIL); r.timer = TMR_CANCEL; end
        endcase
      end
      default: begin fail_code(RES_FAIL); r.timer = TMR_CANCEL; end
    endcase
  endfunction

  function automatic void on_callback();
    r.timer = TMR_CANCEL;
    case (cmd_code)
      CMD_WR_ONE, CMD_WR_MULTI, CMD_WRD_ONE, CMD_WRD_MULTI: begin
        if (!phase) begin
          trk[cur_drv] = pbytes[0]; sector_req(OP_WRITE); phase = 1;
        end else begin
          if (sector_done()) return;
          bytes_left = sec_bytes; sector_req(OP_WRITE);
        end
        st_reg = ST_XFER; res_reg = '0;
      end
      CMD_RD_ONE, CMD_RD_MULTI, CMD_RDD_ONE, CMD_VFY_ONE, CMD_VFY_MULTI: begin
        if (!phase) begin
          trk[cur_drv] = pbytes[0]; phase = 1;
        end else if (sector_done()) begin
          return;
        end
        bytes_left = sec_bytes; sector_req(OP_READ);
      end
      CMD_RD_ID: begin
        if (!phase) begin
          trk[cur_drv] = pbytes[0]; phase = 1;
        end else begin
          if (sector_done()) return;
          bytes_left = 16'd4;
        end
        sector_req(OP_READ_ID);
      end
      CMD_FORMAT: begin
        if (!phase) begin
          trk[cur_drv] = pbytes[0];
          r.op = OP_FORMAT; r.track = pbytes[0]; r_operand = int'(pbytes[2]);
          st_reg = ST_XFER; phase = 1;
        end else begin
          st_reg = ST_DONE; res_reg = '0;
        end
      end
      CMD_SEEK: begin
        trk[cur_drv] = pbytes[0]; st_reg = ST_DONE; res_reg = '0; timed_down();
      end
      default: ;
    endcase
  endfunction

  function automatic fdc_result_t predict_result(logic [3:0] mode, logic [23:0] d,
                                                 logic last);
    logic [2:0] addr;
    logic [7:0] wv;
    addr = d[2:0];
    wv = d[10:3];
    r = '0;
    r.rd = 9'h1FF;
    r_operand = 0;
    case (mode_t'(mode))
      MODE_BUS_RD: begin
        if (addr == ADDR_STATUS) r.rd = {1'b0, st_reg};
        else if (addr == ADDR_RESULT) begin
          st_reg &= ~8'h18; r.rd = {1'b0, res_reg};
        end else if (addr == ADDR_DATA) begin
          st_reg &= ~8'h0C; r.rd = {1'b0, data_reg};
        end else r.rd = '0;
      end
      MODE_BUS_WR: begin
        if (addr == ADDR_STATUS) on_command(wv);
        else if (addr == ADDR_RESULT) on_param(wv);
        else if (addr == ADDR_RESET) begin
          if (wv[0]) begin
            r.motor = MOT_TIMED; r_operand = 45000; r.timer = TMR_CANCEL;
            pcount = 0; pneed = 0; st_reg = '0;
            trk[0] = '0; trk[1] = '0; cmd_code = CMD_NONE;
          end
        end else if (addr == ADDR_DATA) begin
          data_reg = wv; data_wr = 1; st_reg &= ~8'h0C;
        end
      end
      MODE_CALLBACK: on_callback();
      MODE_DATA_BYTE: begin
        if (bytes_left != 0) begin
          bytes_left--; data_reg = d[18:11]; st_reg = ST_XFER; res_reg = '0;
        end
      end
      MODE_FINISH_RD: begin
        r.timer = TMR_SCHED;
        if (d[19]) res_reg |= RES_DELETED;
      end
      MODE_NOT_FOUND: begin fail_code(RES_FAIL); short_down(); end
      MODE_DATA_CRC: begin
        fail_code(d[19] ? (RES_DATA_CRC | RES_DELETED) : RES_DATA_CRC); short_down();
      end
      MODE_HDR_CRC: begin fail_code(RES_HDR_CRC); short_down(); end
      MODE_WR_PROT: begin fail_code(RES_WR_PROT); short_down(); end
      MODE_BYTE_WANT: begin
        if (data_wr) begin
          if (!last) begin st_reg = ST_XFER; res_reg = '0; end
          data_wr = 0; r.rd = {1'b0, data_reg};
        end
      end
      MODE_SPINDOWN: begin
        if (motor_on) begin motor_on = 0; r.motor = MOT_OFF; end
        drv_out &= 8'h3F;
      end
      default: ;
    endcase
    r.status = st_reg;
    r.drive = cur_drv;
    r.side = drv_out[5];
    r.operand = r_operand[16:0];
    return r;
  endfunction

  // Unpacks the result bus, lowest field first.
  function automatic fdc_result_t unpack_result(logic [95:0] t);
    fdc_result_t u;
    u.rd = t[8:0];       u.status = t[16:9];   u.op = t[19:17];
    u.drive = t[20];     u.side = t[21];       u.track = t[29:22];
    u.operand = t[46:30]; u.incl = t[47];      u.motor = t[50:48];
    u.timer = t[52:51];  u.step = t[71:53];    u.settle = t[90:72];
    return u;
  endfunction

  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, e, a);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    fdc_result_t e, a;
    if (rst_n && out_tvalid && out_tready) begin
      a = unpack_result(out_tdata);
      if (expected_items.size() == 0) begin
        $display("%0t: unexpected result item 0x%0h", $time, out_tdata);
        n_errors++;
      end else begin
        e = expected_items.pop_front();
        check_field("read_value", 32'(e.rd), 32'(a.rd));
        check_field("status", 32'(e.status), 32'(a.status));
        check_field("disc_op", 32'(e.op), 32'(a.op));
        check_field("drive", 32'(e.drive), 32'(a.drive));
        check_field("side", 32'(e.side), 32'(a.side));
        check_field("track", 32'(e.track), 32'(a.track));
        check_field("operand", 32'(e.operand), 32'(a.operand));
        check_field("include_deleted", 32'(e.incl), 32'(a.incl));
        check_field("motor_cmd", 32'(e.motor), 32'(a.motor));
        check_field("timer_cmd", 32'(e.timer), 32'(a.timer));
        check_field("step_cycles", 32'(e.step), 32'(a.step));
        check_field("settle_cycles", 32'(e.settle), 32'(a.settle));
      end
    end
  end

  // Result-side back-pressure in random bursts.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_item(logic [3:0] mode, logic [2:0] addr, logic [7:0] wv,
                           logic [7:0] db, logic del, logic last);
    logic [23:0] d;
    d = {4'd0, del, db, wv, addr};
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tlast <= last;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    expected_items.push_back(predict_result(mode, d, last));
  endtask

  task automatic bus_write(logic [2:0] addr, logic [7:0] v);
    send_item(MODE_BUS_WR, addr, v, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic bus_read(logic [2:0] addr);
    send_item(MODE_BUS_RD, addr, 8'($urandom), 8'($urandom), 1'($urandom),
              1'($urandom));
  endtask

  task automatic drive_event(logic [3:0] mode, logic [7:0] db, logic del, logic last);
    send_item(mode, 3'($urandom), 8'($urandom), db, del, last);
  endtask

  // Fills every parameter slot before anything can read one.
  task automatic test_fill_params();
    bus_write(ADDR_STATUS, CMD_SCAN_A);
    repeat (5) bus_write(ADDR_RESULT, 8'($urandom));
  endtask

  task automatic test_directed();
    bus_read(ADDR_STATUS);
    bus_read(ADDR_RESULT);
    bus_read(ADDR_DATA);
    bus_read(3'd7);
    bus_write(ADDR_RESET, 8'h01);
    bus_write(ADDR_STATUS, CMD_SPECIFY);
    bus_write(ADDR_RESULT, SPEC_INIT);
    bus_write(ADDR_RESULT, 8'hFF);
    bus_write(ADDR_RESULT, 8'hFF);
    bus_write(ADDR_RESULT, 8'hFF);
    bus_write(ADDR_STATUS, 8'h80 | CMD_SEEK);
    bus_write(ADDR_RESULT, 8'hFF);
    bus_write(ADDR_STATUS, CMD_BAD);          // ignored while busy
    drive_event(MODE_CALLBACK, 8'h00, 1'b0, 1'b0);
    bus_write(ADDR_STATUS, CMD_BAD);
    bus_write(ADDR_DATA, 8'hFF);
    drive_event(MODE_BYTE_WANT, 8'h00, 1'b0, 1'b1);
    drive_event(MODE_DATA_BYTE, 8'hFF, 1'b1, 1'b0);
    drive_event(MODE_FINISH_RD, 8'h00, 1'b1, 1'b0);
    drive_event(MODE_DATA_CRC, 8'h00, 1'b1, 1'b0);
    drive_event(MODE_SPINDOWN, 8'h00, 1'b0, 1'b0);
    drive_event(4'd15, 8'hFF, 1'b1, 1'b1);
    bus_write(ADDR_STATUS, CMD_STATUS);
    bus_read(ADDR_RESULT);
  endtask

  function automatic logic [7:0] pick_command();
    logic [7:0] cmds [19];
    cmds = '{CMD_SCAN_A, CMD_WR_ONE, CMD_WR_MULTI, CMD_WRD_ONE, CMD_WRD_MULTI,
             CMD_RD_ONE, CMD_RD_MULTI, CMD_RDD_ONE, CMD_RDD_MULTI, CMD_RD_ID,
             CMD_VFY_ONE, CMD_VFY_MULTI, CMD_FORMAT, CMD_SEEK, CMD_STATUS,
             CMD_SPECIFY, CMD_WR_SPEC, CMD_RD_SPEC, CMD_BAD};
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return {2'($urandom_range(0, 3)), 6'd0} | cmds[$urandom_range(0, 18)];
  endfunction

  function automatic logic [7:0] pick_param(int idx);
    logic [7:0] regs [5];
    regs = '{SR_SCAN, SR_TRK0, SR_MODE, SR_TRK1, SR_DRVOUT};
    if (idx == 0 && $urandom_range(0, 2) == 0) return regs[$urandom_range(0, 4)];
    if (idx == 0 && $urandom_range(0, 3) == 0) return SPEC_INIT;
    if (idx == 2 && $urandom_range(0, 1) == 0)
      return 8'($urandom_range(0, 7)) | 8'h20;
    return 8'($urandom);
  endfunction

  // Command sequences with random content and parameter counts near the needed number, plus some noise.
  task automatic run_sequences(int n_items);
    int sent, np, k;
    logic [3:0] m;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(4'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom), 1'($urandom));
        sent++;
        continue;
      end
      if (st_reg[7] && $urandom_range(0, 2) != 0) begin
        bus_write(ADDR_RESET, 8'($urandom) | 8'h01);
        sent++;
      end
      bus_write(ADDR_STATUS, pick_command());
      np = pneed + int'($urandom_range(0, 4)) - 1;
      for (k = 0; k < np; k++) bus_write(ADDR_RESULT, pick_param(k));
      sent += 1 + (np > 0 ? np : 0);
      repeat ($urandom_range(3, 14)) begin
        m = 4'($urandom_range(0, 10));
        if ($urandom_range(0, 2) == 0) m = MODE_CALLBACK;
        else if ($urandom_range(0, 3) == 0) m = MODE_DATA_BYTE;
        if (m == MODE_BUS_WR) bus_write($urandom_range(0, 1) ? ADDR_DATA : 3'($urandom),
                                        8'($urandom));
        else send_item(m, 3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                       1'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    run_sequences(1000);
  endtask

  task automatic test_steady_tail();
    calm = 1'b1;
    run_sequences(300);
  endtask

  initial begin
    #(12 * 1000000);
    $display("tb_floppy_disk_controller_core NOT OK");
    $finish;
  end

  initial begin
    clear_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_fill_params();
    test_directed();
    test_random();
    test_steady_tail();
    in_tvalid <= 1'b0;
    wait (expected_items.size() == 0);
    repeat (5) @(posedge clk);
    if (n_errors == 0) $display("tb_floppy_disk_controller_core OK");
    else $display("tb_floppy_disk_controller_core NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fdc_pkg.sv
hw/rtl/floppy_disk_controller_core.sv
dv/tb_floppy_disk_controller_core.sv
